/* rtl/core/pidc_pkg.sv */
package pidc_pkg;

	// Item kinds
	localparam logic [1:0] KIND_COMPUTE = 2'd0;
	localparam logic [1:0] KIND_AUTO    = 2'd1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX    = 3'd5;

	localparam int GAIN_W  = 24;
	localparam int SIG_W   = 16;
	localparam int ERR_W   = 17;
	localparam int DERR_W  = 18;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = GAIN_W + 1 + ERR_W;   // gain (as signed) x error
	localparam int DPROD_W = GAIN_W + 1 + DERR_W;  // gain (as signed) x error change
	localparam int SUM_W   = 45;                   // drive sum, Q.16
	localparam int CLIP_W  = 32;                   // width seen by the clamp

	typedef struct packed {
		logic [GAIN_W-1:0]       prop_gain;
		logic [GAIN_W-1:0]       integ_gain;
		logic [GAIN_W-1:0]       deriv_gain;
		logic                    reverse_mode;
		logic signed [SIG_W-1:0] drive_min;
		logic signed [SIG_W-1:0] drive_max;
	} pidc_cfg_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [SIG_W-1:0] setpoint;
		logic signed [SIG_W-1:0] measurement;
		logic signed [SIG_W-1:0] held_output;
	} pidc_sample_t;

	typedef struct packed {
		logic                      compute;
		logic                      mode_chg;
		logic                      auto_mode;
		logic signed [SIG_W-1:0]   held_output;
		logic signed [PROD_W-1:0]  prop_term;
		logic signed [PROD_W-1:0]  integ_term;
		logic signed [DPROD_W-1:0] deriv_term;
	} pidc_prod_t;

	typedef struct packed {
		logic signed [SIG_W-1:0] drive;
		logic                    computed;
		logic                    automatic_res;
	} pidc_result_t;

	// Upper is tested first: inverted limits give hi above hi, else lo.
	function automatic logic signed [SIG_W-1:0] clamp_lim(
		input logic signed [CLIP_W-1:0] v,
		input logic signed [SIG_W-1:0]  lo,
		input logic signed [SIG_W-1:0]  hi
	);
		logic signed [CLIP_W-1:0] lo_x;
		logic signed [CLIP_W-1:0] hi_x;
		lo_x = CLIP_W'(lo);
		hi_x = CLIP_W'(hi);
		if (v > hi_x) begin
			return hi;
		end else if (v < lo_x) begin
			return lo;
		end else begin
			return v[SIG_W-1:0];
		end
	endfunction

endpackage

/* rtl/core/pidc_if.sv */
interface pidc_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [15:0] setpoint;
	logic signed [15:0] measurement;
	logic signed [15:0] held_output;

	modport source(output valid, kind, setpoint, measurement, held_output, input ready);
	modport sink(input valid, kind, setpoint, measurement, held_output, output ready);
endinterface

interface pidc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive;
	logic               computed;
	logic               automatic_res;

	modport source(output valid, drive, computed, automatic_res, input ready);
	modport sink(input valid, drive, computed, automatic_res, output ready);
endinterface

/* rtl/core/pidc_cfg_regs.sv */
module pidc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidc_pkg::GAIN_W-1:0]      cfg_wdata,
	output pidc_pkg::pidc_cfg_t              cfg
);

	pidc_pkg::pidc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= '0;
			cfg_q.integ_gain   <= '0;
			cfg_q.deriv_gain   <= '0;
			cfg_q.reverse_mode <= 1'b0;
			cfg_q.drive_min    <= 16'sh8000;
			cfg_q.drive_max    <= 16'sh7fff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pidc_pkg::REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_wdata;
				pidc_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_wdata;
				pidc_pkg::REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_wdata;
				pidc_pkg::REG_REVERSE_MODE: cfg_q.reverse_mode <= cfg_wdata[0];
				pidc_pkg::REG_DRIVE_MIN:    cfg_q.drive_min    <= cfg_wdata[15:0];
				pidc_pkg::REG_DRIVE_MAX:    cfg_q.drive_max    <= cfg_wdata[15:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/pidc_mul_stage.sv */
module pidc_mul_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pidc_pkg::pidc_cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pidc_pkg::pidc_sample_t in_data,
	output logic                  prod_valid,
	input  logic                  prod_ready,
	output pidc_pkg::pidc_prod_t  prod
);

	logic                   valid_s1;
	pidc_pkg::pidc_sample_t sample_s1;
	logic                   valid_s2;
	pidc_pkg::pidc_prod_t   prod_s2;

	logic signed [pidc_pkg::ERR_W-1:0] prev_err_q;
	logic                              auto_q;

	logic                               ready_s2;
	logic                               move_s12;
	logic signed [pidc_pkg::ERR_W-1:0]  sp_x;
	logic signed [pidc_pkg::ERR_W-1:0]  meas_x;
	logic signed [pidc_pkg::ERR_W-1:0]  err;
	logic signed [pidc_pkg::DERR_W-1:0] derr;
	logic                               is_compute;
	logic                               want_auto;
	logic                               compute;
	logic                               mode_chg;
	logic                               auto_next;
	pidc_pkg::pidc_prod_t               prod_d;

	assign ready_s2 = !valid_s2 || prod_ready;
	assign move_s12 = valid_s1 && ready_s2;
	assign in_ready = !valid_s1 || ready_s2;

	always_comb begin
		sp_x       = pidc_pkg::ERR_W'(sample_s1.setpoint);
		meas_x     = pidc_pkg::ERR_W'(sample_s1.measurement);
		err        = cfg.reverse_mode ? (sp_x + meas_x) : (sp_x - meas_x);
		derr       = pidc_pkg::DERR_W'(err) - pidc_pkg::DERR_W'(prev_err_q);
		is_compute = (sample_s1.kind == pidc_pkg::KIND_COMPUTE);
		want_auto  = (sample_s1.kind == pidc_pkg::KIND_AUTO);  // kind 3 acts as manual
		compute    = is_compute && auto_q;
		mode_chg   = !is_compute && (want_auto != auto_q);
		auto_next  = is_compute ? auto_q : want_auto;

		prod_d.compute     = compute;
		prod_d.mode_chg    = mode_chg;
		prod_d.auto_mode   = auto_next;
		prod_d.held_output = sample_s1.held_output;
		prod_d.prop_term   = $signed({1'b0, cfg.prop_gain}) * err;
		prod_d.integ_term  = $signed({1'b0, cfg.integ_gain}) * err;
		prod_d.deriv_term  = $signed({1'b0, cfg.deriv_gain}) * derr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			prev_err_q <= '0;
			auto_q     <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s12) begin
				auto_q <= auto_next;
				if (compute) begin
					prev_err_q <= err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_data;
		end
		if (move_s12) begin
			prod_s2 <= prod_d;
		end
	end

	assign prod_valid = valid_s2;
	assign prod       = prod_s2;

endmodule

/* rtl/core/pidc_acc_stage.sv */
module pidc_acc_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pidc_pkg::pidc_cfg_t    cfg,
	input  logic                   prod_valid,
	output logic                   prod_ready,
	input  pidc_pkg::pidc_prod_t   prod,
	output logic                   res_valid,
	input  logic                   res_ready,
	output pidc_pkg::pidc_result_t res
);

	localparam int IRND_W = pidc_pkg::PROD_W - pidc_pkg::FRAC_W;  // rounded increment
	localparam int INEW_W = IRND_W + 1;
	localparam int DRND_W = pidc_pkg::SUM_W - pidc_pkg::FRAC_W;

	logic signed [pidc_pkg::SIG_W-1:0] integ_q;
	logic signed [pidc_pkg::SIG_W-1:0] last_drive_q;
	logic                              res_valid_q;
	pidc_pkg::pidc_result_t            res_q;

	logic                               move;
	logic signed [pidc_pkg::PROD_W-1:0] integ_biased;
	logic signed [IRND_W-1:0]           integ_inc;
	logic signed [INEW_W-1:0]           integ_sum;
	logic signed [pidc_pkg::SIG_W-1:0]  integ_clip;
	logic signed [pidc_pkg::SIG_W-1:0]  held_clip;
	logic signed [pidc_pkg::SUM_W-1:0]  drive_sum;
	logic signed [DRND_W-1:0]           drive_rnd;
	logic signed [pidc_pkg::SIG_W-1:0]  drive_new;
	pidc_pkg::pidc_result_t             res_d;

	assign prod_ready = !res_valid_q || res_ready;
	assign move       = prod_valid && prod_ready;

	always_comb begin
		// round half up, then add and saturate
		integ_biased = prod.integ_term + pidc_pkg::PROD_W'(32768);
		integ_inc    = integ_biased[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];
		integ_sum    = INEW_W'(integ_inc) + INEW_W'(integ_q);
		integ_clip   = pidc_pkg::clamp_lim(pidc_pkg::CLIP_W'(integ_sum),
			cfg.drive_min, cfg.drive_max);
		held_clip    = pidc_pkg::clamp_lim(pidc_pkg::CLIP_W'(prod.held_output),
			cfg.drive_min, cfg.drive_max);

		drive_sum = pidc_pkg::SUM_W'(prod.prop_term)
			+ (pidc_pkg::SUM_W'(integ_clip) <<< pidc_pkg::FRAC_W)
			+ pidc_pkg::SUM_W'(prod.deriv_term)
			+ pidc_pkg::SUM_W'(32768);
		drive_rnd = drive_sum[pidc_pkg::SUM_W-1:pidc_pkg::FRAC_W];
		drive_new = pidc_pkg::clamp_lim(pidc_pkg::CLIP_W'(drive_rnd),
			cfg.drive_min, cfg.drive_max);

		res_d.drive         = prod.compute ? drive_new : last_drive_q;
		res_d.computed      = prod.compute;
		res_d.automatic_res = prod.auto_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q      <= '0;
			last_drive_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (prod_ready) begin
				res_valid_q <= prod_valid;
			end
			if (move) begin
				if (prod.mode_chg) begin
					integ_q <= held_clip;
				end else if (prod.compute) begin
					integ_q      <= integ_clip;
					last_drive_q <= drive_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/core/pid_controller_step.sv */
// PID step with derivative on error and a clamped integral. Each input item is
// one of: compute (error = setpoint - measurement, or setpoint + measurement
// when reverse_mode is set), select automatic, or select manual (kind 3 is
// also manual). Every item returns exactly one result. A compute item in
// automatic mode adds round(ki*error) to the integral and saturates it to
// [drive_min, drive_max], then drives round(kp*error + integral + kd*delta)
// saturated to the same limits; gains are unsigned Q8.16. A compute item in
// manual mode and any mode item return the last drive with computed = 0. A
// real mode change seeds the integral from held_output, clamped. The block
// takes one item per clock while no result is held, and each item moves
// through an input register, a register after the three gain multipliers
// (25x17 for kp and ki, 25x18 for kd), and the result register after the
// integrate/sum/saturate logic. The previous error and the mode close within
// the multiplier stage, the integral and last drive within the last stage,
// so back-to-back items need no stall. Both sides are valid/ready; a held
// result stalls the chain one stage at a time. Gain rescaling for sample
// time and re-clamping on limit writes are up to software, which must write
// configuration only while the block is idle; the block does not enforce it.
module pid_controller_step (
	input  logic                           clk,
	input  logic                           arst_n,
	pidc_in_if.sink                        sample_in,
	pidc_out_if.source                     result_out,
	input  logic                           cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pidc_pkg::GAIN_W-1:0]    cfg_wdata
);

	pidc_pkg::pidc_cfg_t    cfg;
	pidc_pkg::pidc_sample_t sample;
	pidc_pkg::pidc_prod_t   prod;
	pidc_pkg::pidc_result_t res;
	logic                   prod_valid;
	logic                   prod_ready;

	// Packed view of the incoming item
	assign sample.kind        = sample_in.kind;
	assign sample.setpoint    = sample_in.setpoint;
	assign sample.measurement = sample_in.measurement;
	assign sample.held_output = sample_in.held_output;

	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Error, error change and the three gain products
	pidc_mul_stage u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (sample_in.valid),
		.in_ready   (sample_in.ready),
		.in_data    (sample),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	// Integral update, drive sum, saturation and result register
	pidc_acc_stage u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod),
		.res_valid  (result_out.valid),
		.res_ready  (result_out.ready),
		.res        (res)
	);

	assign result_out.drive         = res.drive;
	assign result_out.computed      = res.computed;
	assign result_out.automatic_res = res.automatic_res;

endmodule

/* dv/pid_controller_step_test.sv */
module pid_controller_step_test;

	// Codes the package leaves out
	localparam logic [1:0] KIND_MANUAL = 2'd2;
	localparam logic [1:0] KIND_SPARE  = 2'd3;   // unused code, acts as manual
	localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int LONG_HOLD     = 300;   // receiver hold-off for the backpressure phase
	localparam int SETTLE_CYCLES = 6;     // pipeline is three stages deep

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pidc_pkg::GAIN_W-1:0]    cfg_wdata;

	pidc_in_if  sample_if();
	pidc_out_if result_if();

	pid_controller_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_if),
		.result_out(result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the configuration registers
	logic [23:0]        kp_gain;
	logic [23:0]        ki_gain;
	logic [23:0]        kd_gain;
	logic               rev_mode;
	logic signed [15:0] lim_lo;
	logic signed [15:0] lim_hi;

	// Controller state as the predictor sees it
	logic signed [15:0] integ_acc;
	logic signed [16:0] prev_err;
	logic               ctl_auto;
	logic signed [15:0] last_drive;

	pidc_pkg::pidc_sample_t sample_queue[$];   // items waiting to be offered
	pidc_pkg::pidc_result_t drive_expect_q[$];  // predicted results, oldest first
	pidc_pkg::pidc_sample_t next_sample;
	pidc_pkg::pidc_sample_t taken_sample;
	pidc_pkg::pidc_result_t want;

	int  src_idle_pct;
	int  rcv_stall_pct;
	int  hold_reqs;
	int  hold_served;
	int  hold_left;
	int  fault_count;
	int  cycle_count;
	logic in_took;   // input item accepted at the last rising edge

	always #5 clk = ~clk;

	// Q.16 to integer, round half up (arithmetic shift floors)
	function automatic longint q16_round(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	// Saturate to the drive limits; upper tested first, so inverted limits give lim_hi above lim_hi, else lim_lo
	function automatic logic signed [15:0] saturate(input longint v);
		if (v > longint'(lim_hi)) begin
			return lim_hi;
		end else if (v < longint'(lim_lo)) begin
			return lim_lo;
		end else begin
			return v[15:0];
		end
	endfunction

	// One controller step: updates the predictor state, returns the result
	function automatic pidc_pkg::pidc_result_t pid_predict(input pidc_pkg::pidc_sample_t s);
		pidc_pkg::pidc_result_t r;
		longint sp;
		longint meas;
		longint err;
		longint derr;
		longint sum;
		logic want_auto;
		sp = longint'($signed(s.setpoint));
		meas = longint'($signed(s.measurement));
		r.computed = 1'b0;
		if (s.kind == pidc_pkg::KIND_COMPUTE) begin
			// manual mode: nothing moves
			if (ctl_auto) begin
				err = rev_mode ? sp + meas : sp - meas;
				derr = err - longint'(prev_err);
				integ_acc = saturate(longint'(integ_acc) + q16_round(longint'(ki_gain) * err));
				sum = longint'(kp_gain) * err + longint'(integ_acc) * 65536
					+ longint'(kd_gain) * derr;
				last_drive = saturate(q16_round(sum));
				prev_err = err[16:0];
				r.computed = 1'b1;
			end
		end else begin
			// kind 1 selects automatic, anything else manual
			want_auto = (s.kind == pidc_pkg::KIND_AUTO);
			if (want_auto != ctl_auto) begin
				integ_acc = saturate(longint'($signed(s.held_output)));
			end
			ctl_auto = want_auto;
		end
		r.drive = last_drive;
		r.automatic_res = ctl_auto;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_signal();
		case ($urandom_range(3))
			0: begin
				return 16'($urandom);
			end
			1: begin
				return 16'(int'($urandom_range(400)) - 200);
			end
			2: begin
				case ($urandom_range(3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: begin
				return 16'(int'($urandom_range(8000)) - 4000);
			end
		endcase
	endfunction

	function automatic logic [23:0] rand_gain();
		case ($urandom_range(5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(24'h040000));
		endcase
	endfunction

	task automatic push_sample(input logic [1:0] kind, input logic signed [15:0] sp,
		input logic signed [15:0] meas, input logic signed [15:0] held);
		pidc_pkg::pidc_sample_t s;
		s.kind = kind;
		s.setpoint = sp;
		s.measurement = meas;
		s.held_output = held;
		sample_queue.push_back(s);
	endtask

	// One register write per falling edge; cfg_we stays high across a burst
	// and is lowered by cfg_burst_end.
	task automatic cfg_write(input logic [pidc_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			pidc_pkg::REG_PROP_GAIN:    kp_gain = data;
			pidc_pkg::REG_INTEG_GAIN:   ki_gain = data;
			pidc_pkg::REG_DERIV_GAIN:   kd_gain = data;
			pidc_pkg::REG_REVERSE_MODE: rev_mode = data[0];
			pidc_pkg::REG_DRIVE_MIN:    lim_lo = data[15:0];
			pidc_pkg::REG_DRIVE_MAX:    lim_hi = data[15:0];
			default: ;   // out-of-range index, ignored
		endcase
	endtask

	task automatic cfg_burst_end();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Block is idle once nothing is queued, offered or outstanding
	task automatic drain();
		while (sample_queue.size() != 0 || drive_expect_q.size() != 0 || sample_if.valid) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
			1: begin src_idle_pct = 74; rcv_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  rcv_stall_pct = 74; end
			default: begin src_idle_pct = 20; rcv_stall_pct = 20; end
		endcase
	endtask

	// Driver: new item or idle at the falling edge, held until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
		end else if (!sample_if.valid || in_took) begin
			if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_sample = sample_queue.pop_front();
				sample_if.valid <= 1'b1;
				sample_if.kind <= next_sample.kind;
				sample_if.setpoint <= next_sample.setpoint;
				sample_if.measurement <= next_sample.measurement;
				sample_if.held_output <= next_sample.held_output;
			end else begin
				sample_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (hold_served != hold_reqs) begin
				hold_served = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// Monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= sample_if.valid && sample_if.ready;
			if (sample_if.valid && sample_if.ready) begin
				taken_sample.kind = sample_if.kind;
				taken_sample.setpoint = sample_if.setpoint;
				taken_sample.measurement = sample_if.measurement;
				taken_sample.held_output = sample_if.held_output;
				drive_expect_q.push_back(pid_predict(taken_sample));
			end
			if (result_if.valid && result_if.ready) begin
				if (drive_expect_q.size() == 0) begin
					fault_count++;
					$display("%0t: result with none expected: drive=%0d computed=%0b auto=%0b",
						$time, $signed(result_if.drive), result_if.computed,
						result_if.automatic_res);
				end else begin
					want = drive_expect_q.pop_front();
					if (result_if.drive !== want.drive ||
						result_if.computed !== want.computed ||
						result_if.automatic_res !== want.automatic_res) begin
						fault_count++;
						$display("%0t: expected drive=%0d comp=%0b auto=%0b, got %0d %0b %0b",
							$time, $signed(want.drive), want.computed, want.automatic_res,
							$signed(result_if.drive), result_if.computed,
							result_if.automatic_res);
					end
				end
			end
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int n;
		int r;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic [1:0] k;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_if.valid = 1'b0;
		sample_if.kind = pidc_pkg::KIND_COMPUTE;
		sample_if.setpoint = '0;
		sample_if.measurement = '0;
		sample_if.held_output = '0;
		result_if.ready = 1'b0;
		in_took = 1'b0;
		fault_count = 0;
		cycle_count = 0;
		hold_reqs = 0;
		hold_served = 0;
		hold_left = 0;
		set_idling(0);

		// reset values of the registers and the state
		kp_gain = '0;
		ki_gain = '0;
		kd_gain = '0;
		rev_mode = 1'b0;
		lim_lo = 16'sh8000;
		lim_hi = 16'sh7FFF;
		integ_acc = '0;
		prev_err = '0;
		ctl_auto = 1'b0;
		last_drive = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset config, zero gains: drive follows the integral alone
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh7FFF, 16'sh8000, 16'sh1234);  // manual compute
		push_sample(KIND_SPARE, 16'sh0000, 16'sh0000, 16'sh0100);   // manual again, no reload
		push_sample(KIND_MANUAL, 16'sh0000, 16'sh0000, 16'sh0200);
		push_sample(pidc_pkg::KIND_AUTO, 16'sh0000, 16'sh0000, 16'sh7FFF);  // seeds integral
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh0000, 16'sh0000, 16'sh0000);
		push_sample(pidc_pkg::KIND_AUTO, 16'sh0000, 16'sh0000, -16'sd5);   // same mode, no reload
		drain();

		// Maximum gains, full-range limits written with junk above bit 15
		cfg_write(pidc_pkg::REG_PROP_GAIN, 24'hFFFFFF);
		cfg_write(pidc_pkg::REG_INTEG_GAIN, 24'hFFFFFF);
		cfg_write(pidc_pkg::REG_DERIV_GAIN, 24'hFFFFFF);
		cfg_write(pidc_pkg::REG_REVERSE_MODE, 24'hFFFFFE);
		cfg_write(pidc_pkg::REG_DRIVE_MIN, 24'hFF8000);
		cfg_write(pidc_pkg::REG_DRIVE_MAX, 24'hA57FFF);
		cfg_burst_end();
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh7FFF, 16'sh8000, 16'sh0000);  // largest error
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh8000, 16'sh7FFF, 16'shFFFF);  // largest swing
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh0000, 16'sh0000, 16'sh0000);
		push_sample(KIND_MANUAL, 16'sh0000, 16'sh0000, 16'sh8000);
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh0100, 16'sh0000, 16'sh0000);  // ignored in manual
		push_sample(pidc_pkg::KIND_AUTO, 16'sh0000, 16'sh0000, 16'sh04D2);
		push_sample(pidc_pkg::KIND_COMPUTE, 16'shFFFF, 16'sh0000, 16'sh0000);
		drain();

		// Reverse mode, half-LSB integral gain, inverted limits, stray indexes
		cfg_write(pidc_pkg::REG_PROP_GAIN, 24'h010000);
		cfg_write(pidc_pkg::REG_INTEG_GAIN, 24'h008000);
		cfg_write(pidc_pkg::REG_DERIV_GAIN, 24'h004000);
		cfg_write(pidc_pkg::REG_REVERSE_MODE, 24'h000001);
		cfg_write(pidc_pkg::REG_DRIVE_MIN, 24'h000064);
		cfg_write(pidc_pkg::REG_DRIVE_MAX, 24'h00FF9C);
		cfg_write(REG_SPARE_6, 24'h5A5A5A);
		cfg_write(REG_SPARE_7, 24'hFFFFFF);
		cfg_burst_end();
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh7FFF, 16'sh7FFF, 16'sh0000);  // sum, not difference
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh8000, 16'sh8000, 16'sh0000);  // most negative error
		push_sample(KIND_SPARE, 16'sh0000, 16'sh0000, 16'sh0000);   // leaves auto, clamp inverted
		push_sample(pidc_pkg::KIND_AUTO, 16'sh0000, 16'sh0000, 16'sh8000);
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh0003, 16'sh0000, 16'sh0000);  // +1.5 rounds up
		drain();
		// Same rounding cases with sane limits
		cfg_write(pidc_pkg::REG_DRIVE_MIN, 24'h00FC18);
		cfg_write(pidc_pkg::REG_DRIVE_MAX, 24'h0003E8);
		cfg_burst_end();
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh0003, 16'sh0000, 16'sh0000);
		push_sample(pidc_pkg::KIND_COMPUTE, -16'sd3, 16'sh0000, 16'sh0000);   // -1.5 rounds to -1
		push_sample(pidc_pkg::KIND_COMPUTE, 16'sh0001, 16'sh0000, 16'sh0000);
		drain();

		// Random phases: each a fresh config, an idling pattern, ~105 items
		for (ph = 0; ph < 8; ph++) begin
			set_idling(ph % 4);
			cfg_write(pidc_pkg::REG_PROP_GAIN, rand_gain());
			cfg_write(pidc_pkg::REG_INTEG_GAIN, rand_gain());
			cfg_write(pidc_pkg::REG_DERIV_GAIN, rand_gain());
			cfg_write(pidc_pkg::REG_REVERSE_MODE, 24'($urandom));
			r = $urandom_range(4);
			a = rand_signal();
			b = rand_signal();
			if (r == 0 || ph == 7) begin
				a = 16'sh8000;
				b = 16'sh7FFF;
			end else if (r == 1) begin
				// inverted limits now and then
				if (a < b) begin
					a = b;
					b = rand_signal();
					if (b > a) b = a;
				end
			end else if (a > b) begin
				a = a ^ b;
				b = a ^ b;
				a = a ^ b;
			end
			cfg_write(pidc_pkg::REG_DRIVE_MIN, {8'($urandom), a});
			cfg_write(pidc_pkg::REG_DRIVE_MAX, {8'($urandom), b});
			cfg_burst_end();

			// Backpressure: long receiver hold while the sender streams
			if (ph == 5) begin
				set_idling(0);
				hold_reqs++;
			end

			push_sample(pidc_pkg::KIND_AUTO, rand_signal(), rand_signal(), 16'($urandom));
			for (n = 0; n < 105; n++) begin
				// mostly computes; mode items keep the loop in auto most of the time
				r = $urandom_range(99);
				if (r < 85) begin
					k = pidc_pkg::KIND_COMPUTE;
				end else if (r < 93) begin
					k = pidc_pkg::KIND_AUTO;
				end else if (r < 97) begin
					k = KIND_MANUAL;
				end else begin
					k = KIND_SPARE;
				end
				push_sample(k, rand_signal(), rand_signal(), 16'($urandom));
			end
			drain();
		end

		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pidc_pkg.sv
rtl/core/pidc_if.sv
rtl/core/pidc_cfg_regs.sv
rtl/core/pidc_mul_stage.sv
rtl/core/pidc_acc_stage.sv
rtl/core/pid_controller_step.sv
dv/pid_controller_step_test.sv
